FILE: rtl/cpfr_pkg.sv
package cpfr_pkg;

  // Frame geometry and lane count
  localparam int CPFR_FRAME_BYTES = 50;
  localparam int CPFR_LANES       = 8;

  // Marker bytes and flag positions
  localparam logic [7:0] CPFR_START_MARK = 8'h5A;
  localparam logic [7:0] CPFR_END_MARK   = 8'hAA;
  localparam int         CPFR_FIX_BIT    = 0;   // mask 0x01
  localparam int         CPFR_RUN_BIT    = 1;   // mask 0x02
  localparam logic [3:0] CPFR_MAX_LEN    = 4'd8;

  // One CAN packet
  typedef struct packed {
    logic [63:0] packet_bytes;
    logic [3:0]  packet_length;
  } cpfr_pkt_t;

  // One reassembled pose
  typedef struct packed {
    logic [63:0] latitude_bits;
    logic [63:0] longitude_bits;
    logic [63:0] altitude_bits;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
    logic [31:0] vel_x_bits;
    logic [31:0] vel_y_bits;
    logic [31:0] vel_z_bits;
    logic        gps_fix;
    logic        running_flag;
  } cpfr_pose_t;

  // Per-packet control shared by all lanes
  typedef struct packed {
    logic       skip;   // byte 0 is the start marker and is dropped
    logic [3:0] len;    // clamped packet length
  } cpfr_lane_ctl_t;

endpackage

FILE: rtl/cpfr_stream_if.sv
interface cpfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cpfr_lane.sv
module cpfr_lane import cpfr_pkg::*; #(
  parameter int FRAME_BYTES = CPFR_FRAME_BYTES,
  parameter int LANE        = 0,
  localparam int CW         = $clog2(FRAME_BYTES + CPFR_LANES)
) (
  input  logic [CW-1:0]  count,
  input  cpfr_lane_ctl_t ctl,
  input  logic [7:0]     byte_in,
  output logic           we,
  output logic [CW-1:0]  pos,
  output logic [7:0]     data
);

  localparam logic [3:0] IDX = 4'(LANE);

  logic active;

  // Byte is live if inside the packet and not the dropped marker
  assign active = (IDX < ctl.len) && (IDX >= {3'b000, ctl.skip});

  // Buffer slot for this byte; overflow bytes are counted but not stored
  assign pos  = count + CW'(LANE) - CW'(ctl.skip);
  assign we   = active && (pos < CW'(FRAME_BYTES));
  assign data = byte_in;

endmodule

FILE: rtl/cpfr_assembler.sv
module cpfr_assembler import cpfr_pkg::*; #(
  parameter int FRAME_BYTES = CPFR_FRAME_BYTES,
  localparam int CW         = $clog2(FRAME_BYTES + CPFR_LANES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  cpfr_pkt_t                      pkt,
  output logic [CW-1:0]                  count,
  output cpfr_lane_ctl_t                 ctl,
  input  logic [CPFR_LANES-1:0]          lane_we,
  input  logic [CPFR_LANES-1:0][CW-1:0]  lane_pos,
  input  logic [CPFR_LANES-1:0][7:0]     lane_data,
  output logic                           res_valid,
  output cpfr_pose_t                     res
);

  logic [7:0]    msg_buf  [FRAME_BYTES];
  logic [7:0]    msg_next [FRAME_BYTES];
  logic          in_message;
  logic [3:0]    len_eff;
  logic          start;
  logic          go;
  logic [CW-1:0] cnt_sum;
  logic          done;

  // Packet decode: clamp length, spot a start marker while idle
  always_comb begin
    len_eff = (pkt.packet_length > CPFR_MAX_LEN) ? CPFR_MAX_LEN : pkt.packet_length;
    start   = !in_message && (len_eff != 4'd0) &&
              (pkt.packet_bytes[7:0] == CPFR_START_MARK);
    go      = fire && (in_message || start);
    ctl.skip = start;
    ctl.len  = len_eff;
    cnt_sum = count + CW'(len_eff) - CW'(start);
    done    = go && (cnt_sum >= CW'(FRAME_BYTES));
  end

  // Merge lane writes into the buffer image
  always_comb begin
    for (int j = 0; j < FRAME_BYTES; j++) begin
      msg_next[j] = msg_buf[j];
      for (int k = 0; k < CPFR_LANES; k++) begin
        if (go && lane_we[k] && (lane_pos[k] == CW'(j))) begin
          msg_next[j] = lane_data[k];
        end
      end
    end
  end

  // Pose fields straight from the updated image
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      res.latitude_bits[8*b +: 8]  = msg_next[b];
      res.longitude_bits[8*b +: 8] = msg_next[8 + b];
      res.altitude_bits[8*b +: 8]  = msg_next[16 + b];
    end
    for (int b = 0; b < 4; b++) begin
      res.roll_bits[8*b +: 8]  = msg_next[24 + b];
      res.pitch_bits[8*b +: 8] = msg_next[28 + b];
      res.yaw_bits[8*b +: 8]   = msg_next[32 + b];
      res.vel_x_bits[8*b +: 8] = msg_next[36 + b];
      res.vel_y_bits[8*b +: 8] = msg_next[40 + b];
      res.vel_z_bits[8*b +: 8] = msg_next[44 + b];
    end
    res.gps_fix      = msg_next[FRAME_BYTES-2][CPFR_FIX_BIT];
    res.running_flag = msg_next[FRAME_BYTES-2][CPFR_RUN_BIT];
    res_valid        = done && (msg_next[FRAME_BYTES-1] == CPFR_END_MARK);
  end

  // Message control
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      in_message <= 1'b0;
    end else if (go) begin
      if (done) begin
        count      <= '0;
        in_message <= 1'b0;
      end else begin
        count      <= cnt_sum;
        in_message <= 1'b1;
      end
    end
  end

  // Buffer storage, no reset
  always_ff @(posedge clk) begin
    if (go) begin
      for (int j = 0; j < FRAME_BYTES; j++) begin
        msg_buf[j] <= msg_next[j];
      end
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CW'(FRAME_BYTES))
    else $error("byte count reached frame size between packets");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !in_message |-> (count == '0))
    else $error("idle with non-zero byte count");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !in_message && (count == '0))
    else $error("still in a message after emitting a pose");

endmodule

FILE: rtl/cpfr_out_buf.sv
module cpfr_out_buf import cpfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cpfr_pose_t  push_data,
  output logic        full,
  cpfr_stream_if.source pose
);

  logic       out_valid;
  logic       skid_valid;
  cpfr_pose_t out_data;
  cpfr_pose_t skid_data;
  logic       pop;

  assign pop          = out_valid && pose.ready;
  assign pose.valid   = out_valid;
  assign pose.payload = out_data;
  assign full         = skid_valid;

  // Output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Word storage
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("pose pushed while both stages are full");

endmodule

FILE: rtl/can_pose_frame_reassembler.sv
// A pose completed by a packet is registered into the output stage, or into the skid stage while the output is held.
// One packet per cycle while the skid stage is empty; the eight byte lanes store a whole packet at once.
// A stalled output holds one pose plus one in the skid stage; the input stalls only
// when both are full.
// Reset (rst, synchronous): idle, byte count zero, output empty; buffer not cleared.
module can_pose_frame_reassembler import cpfr_pkg::*; #(
  parameter int FRAME_BYTES = CPFR_FRAME_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  cpfr_stream_if.sink   pkt,
  cpfr_stream_if.source pose
);

  localparam int CW = $clog2(FRAME_BYTES + CPFR_LANES);

  logic                          fire;
  logic                          full;
  logic [CW-1:0]                 count;
  cpfr_lane_ctl_t                ctl;
  logic [CPFR_LANES-1:0]         lane_we;
  logic [CPFR_LANES-1:0][CW-1:0] lane_pos;
  logic [CPFR_LANES-1:0][7:0]    lane_data;
  logic                          res_valid;
  cpfr_pose_t                    res;
  cpfr_pkt_t                     pkt_word;

  assign pkt_word  = pkt.payload;
  assign pkt.ready = !full;
  assign fire      = pkt.valid && pkt.ready;

  // One lane per payload byte
  for (genvar g = 0; g < CPFR_LANES; g++) begin : g_lane
    cpfr_lane #(
      .FRAME_BYTES (FRAME_BYTES),
      .LANE        (g)
    ) u_lane (
      .count   (count),
      .ctl     (ctl),
      .byte_in (pkt_word.packet_bytes[8*g +: 8]),
      .we      (lane_we[g]),
      .pos     (lane_pos[g]),
      .data    (lane_data[g])
    );
  end

  // Buffer, count and completion
  cpfr_assembler #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_assembler (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .pkt       (pkt_word),
    .count     (count),
    .ctl       (ctl),
    .lane_we   (lane_we),
    .lane_pos  (lane_pos),
    .lane_data (lane_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with skid
  cpfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .pose      (pose)
  );

endmodule
